[hdl/olrb_pkg.sv]
// Shared constants and types for the overwriting log ring buffer.
`timescale 1ns / 1ps
package olrb_pkg;

  localparam int LOG_DEPTH = 4096;
  localparam int IDX_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int LAPS_W    = 32;
  localparam int POS_W     = 44;

  typedef enum logic [2:0] {
    CMD_WRITE     = 3'd0,
    CMD_READ      = 3'd1,
    CMD_SEEK_HEAD = 3'd2,
    CMD_SEEK_CUR  = 3'd3,
    CMD_SEEK_TAIL = 3'd4
  } cmd_t;

endpackage

[hdl/overwriting_log_ring_buffer_top.sv]
// Overwriting byte log ring with lap counters, ring RAM and result pipeline.
//
//   channel   | dir | handshake            | payload
//   ----------+-----+----------------------+-----------------------------------------
//   command   | in  | s_tvalid / s_tready  | s_tuser: command; s_tdata: byte, offset
//   result    | out | m_tvalid / m_tready  | m_tuser: valid, status; m_tdata: byte, pos
//
// One item per cycle while the output is not stalled: pointer update and the
// ring RAM access happen at the input transfer; the registered RAM read data
// joins the result in a holding stage, then an output register. Reset (rst,
// synchronous) clears pointers, laps and valid flags; the ring RAM is not
// cleared. A stalled output holds the result and the holding stage, and input
// stalls only once both are full.
`timescale 1ns / 1ps
module overwriting_log_ring_buffer_top
  import olrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [7:0] write_data, [39:8] seek_offset, rest zero
  input  logic [2:0]  s_tuser,   // [2:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] read_data, [51:8] position, rest zero
  output logic [1:0]  m_tuser    // [0] data_valid, [1] status
);

  // ring RAM
  logic [7:0] log_mem [LOG_DEPTH];
  logic [7:0] mem_q;

  // pointers
  logic [IDX_W-1:0]  write_index, write_index_next;
  logic [IDX_W-1:0]  read_index, read_index_next;
  logic [LAPS_W-1:0] write_laps, write_laps_next;
  logic [LAPS_W-1:0] read_laps, read_laps_next;

  // holding stage
  logic              s1_valid;
  logic              s1_rd;
  logic              s1_dvalid;
  logic              s1_status;
  logic              s1_pos_en;
  logic [LAPS_W-1:0] s1_laps;
  logic [IDX_W-1:0]  s1_idx;

  // output register
  logic [7:0]        out_data;
  logic              out_dvalid;
  logic              out_status;
  logic [POS_W-1:0]  out_pos;

  logic              accept;
  logic              s1_move;
  cmd_t              cmd;
  logic [7:0]        wr_byte;
  logic              off_nz;
  logic [IDX_W:0]    w_next;
  logic [IDX_W:0]    r_next;
  logic              w_wrap, r_wrap, ahead, drag, empty;
  logic              do_write, do_read;
  logic              rd_ok, dvalid_c, status_c, pos_en_c;

  assign cmd     = cmd_t'(s_tuser);
  assign wr_byte = s_tdata[7:0];
  assign off_nz  = (s_tdata[39:8] != 32'd0);

  assign s1_move  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_move;
  assign accept   = s_tvalid && s_tready;

  assign w_next = {1'b0, write_index} + (IDX_W+1)'(1);
  assign r_next = {1'b0, read_index} + (IDX_W+1)'(1);
  assign w_wrap = (w_next == (IDX_W+1)'(LOG_DEPTH));
  assign r_wrap = (r_next == (IDX_W+1)'(LOG_DEPTH));
  assign ahead  = (write_laps > read_laps);
  assign drag   = ahead && (w_next >= {1'b0, read_index});
  assign empty  = (read_index == write_index) && (read_laps >= write_laps);

  always_comb begin
    write_index_next = write_index;
    write_laps_next  = write_laps;
    read_index_next  = read_index;
    read_laps_next   = read_laps;
    do_write = 1'b0;
    do_read  = 1'b0;
    rd_ok    = 1'b0;
    dvalid_c = 1'b0;
    status_c = 1'b0;
    pos_en_c = 1'b0;
    unique case (cmd)
      CMD_WRITE: begin
        do_write = 1'b1;
        dvalid_c = 1'b1;
        write_index_next = w_wrap ? '0 : w_next[IDX_W-1:0];
        write_laps_next  = w_wrap ? write_laps + LAPS_W'(1) : write_laps;
        // drag the reader along when the writer laps it
        if (drag) begin
          read_index_next = w_wrap ? '0 : w_next[IDX_W-1:0];
          read_laps_next  = w_wrap ? read_laps + LAPS_W'(1) : read_laps;
        end
      end
      CMD_READ: begin
        if (!empty) begin
          do_read  = 1'b1;
          rd_ok    = 1'b1;
          dvalid_c = 1'b1;
          read_index_next = r_wrap ? '0 : r_next[IDX_W-1:0];
          read_laps_next  = r_wrap ? read_laps + LAPS_W'(1) : read_laps;
        end
      end
      CMD_SEEK_HEAD, CMD_SEEK_CUR, CMD_SEEK_TAIL: begin
        if (off_nz) begin
          status_c = 1'b1;
        end else begin
          pos_en_c = 1'b1;
          if (cmd == CMD_SEEK_HEAD) begin
            if (write_laps != '0) begin
              read_index_next = write_index;
              read_laps_next  = write_laps - LAPS_W'(1);
            end else begin
              read_index_next = '0;
              read_laps_next  = '0;
            end
          end else if (cmd == CMD_SEEK_TAIL) begin
            read_index_next = write_index;
            read_laps_next  = write_laps;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      write_laps  <= '0;
      read_laps   <= '0;
    end else if (accept) begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      write_laps  <= write_laps_next;
      read_laps   <= read_laps_next;
    end
  end

  // RAM write and registered read; reads only on transfer so mem_q holds
  // while the holding stage stalls
  always_ff @(posedge clk) begin
    if (accept && do_write) begin
      log_mem[write_index] <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_read) begin
      mem_q <= log_mem[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd     <= rd_ok;
      s1_dvalid <= dvalid_c;
      s1_status <= status_c;
      s1_pos_en <= pos_en_c;
      s1_laps   <= read_laps_next;
      s1_idx    <= read_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data   <= s1_rd ? mem_q : 8'd0;
      out_dvalid <= s1_dvalid;
      out_status <= s1_status;
      out_pos    <= s1_pos_en
                    ? POS_W'(s1_laps) * POS_W'(LOG_DEPTH) + POS_W'(s1_idx)
                    : '0;
    end
  end

  assign m_tdata = {4'd0, out_pos, out_data};
  assign m_tuser = {out_status, out_dvalid};

`ifndef SYNTH
  a_no_byte_reads_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
    else $error("result without a byte carries nonzero data");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata[51:8] == '0)
    else $error("rejected seek reports data or position");

  a_write_advances: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_WRITE |=>
      write_index == (($past(write_index) == IDX_W'(LOG_DEPTH - 1)) ? '0
                      : $past(write_index) + IDX_W'(1)))
    else $error("write index did not advance");

  a_hold_stalls: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_idx) && $stable(s1_laps))
    else $error("holding stage lost a stalled result");
`endif

endmodule

[sim/tb_overwriting_log_ring_buffer_top.sv]
// Self-checking testbench for the overwriting log ring buffer top level.
`timescale 1ns / 1ps
module tb_overwriting_log_ring_buffer_top
  import olrb_pkg::*;
();

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MIX_ITEMS    = 60;
  localparam int PHASES       = 6;

  // Command codes outside the defined set; the block must answer them with zeros.
  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  localparam logic BY_TABLE = 1'b1;
  localparam logic BY_MODEL = 1'b0;

  typedef struct packed {
    logic [7:0]       read_data;
    logic             data_valid;
    logic             status;
    logic [POS_W-1:0] position;
  } log_result_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  data;
    logic [31:0] offset;
    logic        typed;
    log_result_t want;
  } stim_row_t;

  typedef struct packed {
    logic        typed;
    log_result_t want;
  } item_tag_t;

  localparam log_result_t NO_DATA  = '{8'h00, 1'b0, 1'b0, {POS_W{1'b0}}};
  localparam log_result_t STORED   = '{8'h00, 1'b1, 1'b0, {POS_W{1'b0}}};
  localparam log_result_t REJECTED = '{8'h00, 1'b0, 1'b1, {POS_W{1'b0}}};

  localparam int DIR_ROWS = 24;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{CMD_READ,      8'h00, 32'h0000_0000, BY_TABLE, NO_DATA},
    '{CMD_SEEK_HEAD, 8'h00, 32'h0000_0000, BY_TABLE, NO_DATA},
    '{CMD_SEEK_CUR,  8'h00, 32'h0000_0000, BY_TABLE, NO_DATA},
    '{CMD_SEEK_TAIL, 8'h00, 32'h0000_0000, BY_TABLE, NO_DATA},
    '{CMD_SEEK_CUR,  8'h00, 32'h8000_0000, BY_TABLE, REJECTED},
    '{CMD_SEEK_HEAD, 8'h00, 32'h7FFF_FFFF, BY_TABLE, REJECTED},
    '{CMD_SEEK_TAIL, 8'h00, 32'hFFFF_FFFF, BY_TABLE, REJECTED},
    '{CMD_SEEK_TAIL, 8'h00, 32'h0000_0001, BY_TABLE, REJECTED},
    '{CMD_WRITE,     8'h00, 32'h0000_0000, BY_TABLE, STORED},
    '{CMD_WRITE,     8'hFF, 32'h0000_0000, BY_TABLE, STORED},
    '{CMD_WRITE,     8'hA5, 32'hFFFF_FFFF, BY_TABLE, STORED},
    '{CMD_SEEK_TAIL, 8'h00, 32'h0000_0000, BY_MODEL, NO_DATA},
    '{CMD_READ,      8'h00, 32'h0000_0000, BY_MODEL, NO_DATA},
    '{CMD_SEEK_HEAD, 8'h00, 32'h0000_0000, BY_MODEL, NO_DATA},
    '{CMD_READ,      8'h00, 32'h0000_0000, BY_MODEL, NO_DATA},
    '{CMD_READ,      8'h00, 32'h0000_0000, BY_MODEL, NO_DATA},
    '{CMD_READ,      8'h00, 32'h0000_0000, BY_MODEL, NO_DATA},
    '{CMD_READ,      8'h00, 32'h0000_0000, BY_MODEL, NO_DATA},
    '{CMD_SEEK_CUR,  8'h00, 32'h0000_0000, BY_MODEL, NO_DATA},
    '{CMD_RSVD_5,    8'hFF, 32'hFFFF_FFFF, BY_TABLE, NO_DATA},
    '{CMD_RSVD_6,    8'h5A, 32'h0000_0001, BY_TABLE, NO_DATA},
    '{CMD_RSVD_7,    8'h00, 32'h0000_0000, BY_TABLE, NO_DATA},
    '{CMD_WRITE,     8'h5A, 32'h8000_0000, BY_TABLE, STORED},
    '{CMD_READ,      8'h00, 32'h7FFF_FFFF, BY_MODEL, NO_DATA}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;

  // Shadow copy of the ring and its two positions
  logic [7:0]        shadow_ring [LOG_DEPTH];
  logic [IDX_W-1:0]  wr_idx  = '0;
  logic [IDX_W-1:0]  rd_idx  = '0;
  logic [LAPS_W-1:0] wr_laps = '0;
  logic [LAPS_W-1:0] rd_laps = '0;

  item_tag_t   item_tags[$];
  log_result_t expected_results[$];

  int mismatches    = 0;
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int quiet_cycles  = 0;

  overwriting_log_ring_buffer_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch on %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Advance the shadow ring by one command and return the answer it owes.
  task automatic predict_log_step(input logic [2:0] cmd, input logic [7:0] data,
                                  input logic [31:0] offset, output log_result_t res);
    logic [IDX_W:0] nxt;
    logic           drag;
    logic           wrapped;
    logic [63:0]    abs_pos;
    res = NO_DATA;
    case (cmd)
      CMD_WRITE: begin
        shadow_ring[wr_idx] = data;
        nxt     = {1'b0, wr_idx} + 1'b1;
        drag    = (wr_laps > rd_laps) && (nxt >= {1'b0, rd_idx});
        wrapped = (nxt >= LOG_DEPTH);
        if (wrapped) begin
          wr_laps = wr_laps + 1'b1;
          nxt     = '0;
        end
        wr_idx = nxt[IDX_W-1:0];
        // A writer a lap ahead pushes the reader along
        if (drag) begin
          rd_idx = wr_idx;
          if (wrapped) rd_laps = rd_laps + 1'b1;
        end
        res.data_valid = 1'b1;
      end
      CMD_READ: begin
        if (!(rd_idx == wr_idx && rd_laps >= wr_laps)) begin
          res.read_data  = shadow_ring[rd_idx];
          res.data_valid = 1'b1;
          nxt = {1'b0, rd_idx} + 1'b1;
          if (nxt >= LOG_DEPTH) begin
            rd_laps = rd_laps + 1'b1;
            nxt     = '0;
          end
          rd_idx = nxt[IDX_W-1:0];
        end
      end
      CMD_SEEK_HEAD, CMD_SEEK_CUR, CMD_SEEK_TAIL: begin
        if (offset != '0) begin
          res.status = 1'b1;
        end else begin
          if (cmd == CMD_SEEK_HEAD) begin
            if (wr_laps != '0) begin
              rd_idx  = wr_idx;
              rd_laps = wr_laps - 1'b1;
            end else begin
              rd_idx  = '0;
              rd_laps = '0;
            end
          end else if (cmd == CMD_SEEK_TAIL) begin
            rd_idx  = wr_idx;
            rd_laps = wr_laps;
          end
          abs_pos      = 64'(rd_laps) * 64'(LOG_DEPTH) + 64'(rd_idx);
          res.position = abs_pos[POS_W-1:0];
        end
      end
      default: res = NO_DATA;
    endcase
  endtask

  // Offer one command and hold it until the transfer.
  task automatic offer_item(input logic [2:0] cmd, input logic [7:0] data,
                            input logic [31:0] offset, input logic typed,
                            input log_result_t want);
    item_tag_t tag;
    tag.typed = typed;
    tag.want  = want;
    item_tags.push_back(tag);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {8'h00, offset, data};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic offer_random_mix;
    int          pick;
    logic [2:0]  cmd;
    logic [31:0] offset;
    pick   = $urandom_range(0, 99);
    offset = $urandom;
    if (pick < 40) begin
      cmd = CMD_WRITE;
    end else if (pick < 75) begin
      cmd = CMD_READ;
    end else if (pick < 93) begin
      cmd = 3'($urandom_range(CMD_SEEK_HEAD, CMD_SEEK_TAIL));
      // Mostly legal seeks; a few rejected ones
      if ($urandom_range(0, 4) != 0) offset = '0;
    end else begin
      cmd = 3'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
    end
    offer_item(cmd, 8'($urandom_range(0, 255)), offset, BY_MODEL, NO_DATA);
  endtask

  // Receiver: random back-pressure, or a long hold when asked for one
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_done++;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    item_tag_t   tag;
    log_result_t predicted;
    log_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_log_step(s_tuser, s_tdata[7:0], s_tdata[39:8], predicted);
        tag = item_tags.pop_front();
        expected_results.push_back(tag.typed ? tag.want : predicted);
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("result with nothing pending", 64'(m_tdata), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[7:0] !== want.read_data)
            note_mismatch("read_data", 64'(m_tdata[7:0]), 64'(want.read_data));
          if (m_tdata[8 +: POS_W] !== want.position)
            note_mismatch("position", 64'(m_tdata[8 +: POS_W]), 64'(want.position));
          if (m_tuser[0] !== want.data_valid)
            note_mismatch("data_valid", 64'(m_tuser[0]), 64'(want.data_valid));
          if (m_tuser[1] !== want.status)
            note_mismatch("status", 64'(m_tuser[1]), 64'(want.status));
          if (m_tdata[55:8+POS_W] !== '0)
            note_mismatch("tdata padding", 64'(m_tdata[55:8+POS_W]), 64'd0);
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_overwriting_log_ring_buffer_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int burst;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_item(DIRECTED[i].cmd, DIRECTED[i].data, DIRECTED[i].offset,
                 DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: begin
          snd_idle_pct  = 84;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 84;
        end
        3: begin
          snd_idle_pct  = 38;
          rcv_stall_pct = 38;
        end
        4: begin
          // Stop the receiver while writes keep coming, so the input stalls
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
          hold_requests++;
        end
        default: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
        end
      endcase
      // Write runs build up data ahead of the reader
      burst = $urandom_range(80, 120);
      for (int n = 0; n < burst; n++)
        offer_item(CMD_WRITE, 8'($urandom_range(0, 255)), $urandom, BY_MODEL, NO_DATA);
      for (int n = 0; n < MIX_ITEMS; n++)
        offer_random_mix();
      burst = $urandom_range(20, 40);
      for (int n = 0; n < burst; n++)
        offer_item(CMD_READ, 8'($urandom_range(0, 255)), $urandom, BY_MODEL, NO_DATA);
    end

    s_tvalid      <= 1'b0;
    rcv_stall_pct = 0;
    while (item_tags.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_overwriting_log_ring_buffer_top OK");
    end else begin
      $display("tb_overwriting_log_ring_buffer_top NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/olrb_pkg.sv
hdl/overwriting_log_ring_buffer_top.sv
sim/tb_overwriting_log_ring_buffer_top.sv
